>>> rtl/fralu_pkg.sv
// Package with the shared types, constants and helpers of the four-register ALU executor.
`default_nettype none

package fralu_pkg;

  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SHOWN     = 4;

  localparam logic [63:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [3:0] {
    OP_ADDI = 4'd0,
    OP_ADDR = 4'd1,
    OP_BANI = 4'd2,
    OP_BANR = 4'd3,
    OP_BORI = 4'd4,
    OP_BORR = 4'd5,
    OP_EQIR = 4'd6,
    OP_EQRI = 4'd7,
    OP_EQRR = 4'd8,
    OP_GTIR = 4'd9,
    OP_GTRI = 4'd10,
    OP_GTRR = 4'd11,
    OP_MULI = 4'd12,
    OP_MULR = 4'd13,
    OP_SETI = 4'd14,
    OP_SETR = 4'd15
  } op_e;

  typedef struct packed {
    logic        [3:0]  opcode_id;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic        [7:0]  dest_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] reg_zero;
    logic signed [31:0] reg_one;
    logic signed [31:0] reg_two;
    logic signed [31:0] reg_three;
    logic               index_error;
  } out_word_t;

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] rf_t;

  typedef struct packed {
    op_e  op;
    logic a_reg;
    logic b_reg;
    logic err;
  } ctrl_t;

  function automatic out_word_t view_regs(rf_t rf, logic err);
    logic [SHOWN-1:0][DATA_W-1:0] v;
    out_word_t w;
    v = '0;
    for (int k = 0; k < SHOWN; k++) begin
      if (k < NUM_REGS) begin
        v[k] = rf[k];
      end
    end
    w.reg_zero    = v[0];
    w.reg_one     = v[1];
    w.reg_two     = v[2];
    w.reg_three   = v[3];
    w.index_error = err;
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fralu_decode.sv
// Opcode translation, operand usage and register index checking.
`default_nettype none

module fralu_decode
  import fralu_pkg::*;
(
  input  logic [63:0] opcode_map_i,
  input  in_word_t    word_i,
  output ctrl_t       ctrl_o
);

  op_e  op;
  logic a_reg;
  logic b_reg;
  logic a_ok;
  logic b_ok;
  logic c_ok;

  assign op = op_e'(opcode_map_i[{word_i.opcode_id, 2'b00} +: 4]);

  always_comb begin
    unique case (op) inside
      OP_ADDR, OP_BANR, OP_BORR, OP_EQRR, OP_GTRR, OP_MULR: begin
        a_reg = 1'b1;
        b_reg = 1'b1;
      end
      OP_ADDI, OP_BANI, OP_BORI, OP_EQRI, OP_GTRI, OP_MULI, OP_SETR: begin
        a_reg = 1'b1;
        b_reg = 1'b0;
      end
      OP_EQIR, OP_GTIR: begin
        a_reg = 1'b0;
        b_reg = 1'b1;
      end
      default: begin
        a_reg = 1'b0;
        b_reg = 1'b0;
      end
    endcase
  end

  // A negative index reads as a large unsigned value, so one compare covers both bounds.
  assign a_ok = unsigned'(word_i.operand_a) < 32'(NUM_REGS);
  assign b_ok = unsigned'(word_i.operand_b) < 32'(NUM_REGS);
  assign c_ok = word_i.dest_index < 8'(NUM_REGS);

  assign ctrl_o.op    = op;
  assign ctrl_o.a_reg = a_reg;
  assign ctrl_o.b_reg = b_reg;
  assign ctrl_o.err   = !c_ok || (a_reg && !a_ok) || (b_reg && !b_ok);

endmodule

`default_nettype wire

>>> rtl/fralu_alu.sv
// Operand fetch and the sixteen operations of the executor.
`default_nettype none

module fralu_alu
  import fralu_pkg::*;
(
  input  ctrl_t             ctrl_i,
  input  in_word_t          word_i,
  input  rf_t               rf_i,
  output logic [DATA_W-1:0] result_o
);

  logic [DATA_W-1:0] va;
  logic [DATA_W-1:0] vb;
  logic [DATA_W-1:0] prod;

  assign va   = ctrl_i.a_reg ? rf_i[word_i.operand_a[REG_IDX_W-1:0]] : word_i.operand_a;
  assign vb   = ctrl_i.b_reg ? rf_i[word_i.operand_b[REG_IDX_W-1:0]] : word_i.operand_b;
  assign prod = va * vb;

  always_comb begin
    case (ctrl_i.op) inside
      OP_ADDI, OP_ADDR:          result_o = va + vb;
      OP_BANI, OP_BANR:          result_o = va & vb;
      OP_BORI, OP_BORR:          result_o = va | vb;
      OP_EQIR, OP_EQRI, OP_EQRR: result_o = DATA_W'(va == vb);
      OP_GTIR, OP_GTRI, OP_GTRR: result_o = DATA_W'($signed(va) > $signed(vb));
      OP_MULI, OP_MULR:          result_o = prod;
      default:                   result_o = va;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/four_register_alu_executor_core.sv
// Top level of the four-register ALU executor: input register, register file, result register.
// A word in the input register writes its result to the output register when it executes.
// Throughput: one word per cycle unless the output stalls; each instruction reads and writes
// the register file in the execute step between the input register and the result register.
// Reset clears the register file and both pipeline valids and sets the opcode map to identity.
`default_nettype none

module four_register_alu_executor_core
  import fralu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0]       map_q;
  logic              in_valid_q;
  in_word_t          in_word_q;
  logic              out_valid_q;
  out_word_t         out_word_q;
  rf_t               rf_q;
  rf_t               rf_d;
  ctrl_t             ctrl;
  logic [DATA_W-1:0] result;
  logic              exec;

  fralu_decode u_decode (
    .opcode_map_i (map_q),
    .word_i       (in_word_q),
    .ctrl_o       (ctrl)
  );

  fralu_alu u_alu (
    .ctrl_i   (ctrl),
    .word_i   (in_word_q),
    .rf_i     (rf_q),
    .result_o (result)
  );

  assign exec       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec;

  always_comb begin
    rf_d = rf_q;
    if (exec && !ctrl.err) begin
      rf_d[in_word_q.dest_index[REG_IDX_W-1:0]] = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MAP_RESET;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rf_q        <= '0;
    end else begin
      rf_q <= rf_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
    if (exec) begin
      out_word_q <= view_regs(rf_d, ctrl.err);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The input side is held back only while a word waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_valid_q)
    else $error("Input stalled with an empty input register.");

  // A waiting result is never overwritten by a new execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !exec)
    else $error("Execution overwrote a stalled result.");

  // A word with a bad register index leaves the register file untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && ctrl.err) |=> (rf_q == $past(rf_q)))
    else $error("Register file changed on an index error.");

  // A new result appears only after an execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(exec))
    else $error("Result valid rose without an execution.");

  // The flagged error in a fresh result matches the decode of the executed word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (out_word_o.index_error == $past(ctrl.err)))
    else $error("Result error flag does not match the executed word.");

endmodule

`default_nettype wire
